// ----- hdl/c422_pkg.sv -----
// Shared types, constants and the chroma interpolation for the 4:2:2 to 4:4:4 upsampler.
`default_nettype none

package c422_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 8192;
  // Width of row arithmetic; holds row widths up to 65536 plus margin.
  localparam int CALC_W = 18;
  localparam int CFG_W = 14;
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 14'd1920;

  typedef struct packed {
    logic signed [15:0] cr;
    logic signed [15:0] cb;
  } chroma_t;

  // Field order matches s_tdata: luma_even in the lowest bits.
  typedef struct packed {
    logic signed [15:0] cr;
    logic signed [15:0] cb;
    logic signed [15:0] luma_odd;
    logic signed [15:0] luma_even;
  } pair_t;

  // Which pair of the window a result belongs to.
  typedef enum logic [1:0] {
    KIND_PREV2,
    KIND_PREV1,
    KIND_CUR
  } kind_t;

  typedef struct packed {
    pair_t   pd1;
    pair_t   pd0;
    pair_t   cur;
    chroma_t prev;
    logic    p_is0;
    logic    p_is1;
    logic    p_is2;
    logic    odd_cur;
    kind_t   kind;
    kind_t   end_kind;
  } job_t;

  function automatic logic signed [15:0] sat16(input logic [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r = signed'(v[15:0]);
    end
    return r;
  endfunction

  // odd = sat(sat(s+1) - (sat(sat(c+d) - s) >>> 3)) >>> 1, s = sat(a+b)
  function automatic logic signed [15:0] interp(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c,
                                                input logic signed [15:0] d);
    logic signed [15:0] s;
    logic signed [15:0] cd;
    logic signed [15:0] t1;
    logic signed [15:0] t;
    logic signed [15:0] s1;
    logic signed [15:0] o;
    s  = sat16({a[15], a} + {b[15], b});
    cd = sat16({c[15], c} + {d[15], d});
    t1 = sat16({cd[15], cd} - {s[15], s});
    t  = t1 >>> 3;
    s1 = sat16({s[15], s} + 17'd1);
    o  = sat16({s1[15], s1} - {t[15], t});
    return o >>> 1;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/chroma_422_to_444_upsampler_top.sv -----
// Throughput: one pixel pair per clock inside a row while m_tready holds; the row's
//   last pair flushes its results (up to three) one after another, set by the single
//   interpolation unit behind the job register.
// Path: the pair that completes a result's window goes into the job register, and
//   the result then into the output register; in a row, results trail the input by two pairs.
// Reset (rst, synchronous, active high): empty window, row position zero,
//   row_width back to 1920, no request pending on either side.
`default_nettype none

module chroma_422_to_444_upsampler_top import c422_pkg::*; #(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // APB-style configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  // Input pairs
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [63:0]       s_tdata,  // luma_even, luma_odd, cb_even, cr_even
  // Results
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // out_luma_even, out_cb_even, out_cr_even, out_luma_odd, out_cb_odd, out_cr_odd
  output logic [95:0]            m_tdata,
  output logic [0:0]             m_tuser,  // odd_present
  output logic                   m_tlast   // row_last
);

  logic [CFG_W-1:0] row_width;
  logic             cfg_write;
  logic             job_valid;
  logic             job_take;
  job_t             job;

  // Register file: one register, written on the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RST;
    end else if (cfg_write && paddr == REG_ROW_WIDTH) begin
      row_width <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr == REG_ROW_WIDTH) ? APB_DW'(row_width) : '0;

  // Row tracking and the pair window; hands one job per pair that has results.
  c422_ctrl #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_width (row_width),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_take  (job_take),
    .job_valid (job_valid),
    .job       (job)
  );

  // One result per cycle, while the output is not stalled, from the job into the output register.
  c422_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/c422_ctrl.sv -----
// Row tracking, pair window and job register for the upsampler.
`default_nettype none

module c422_ctrl import c422_pkg::*; #(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CFG_W-1:0] row_width,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [63:0]      s_tdata,
  input  wire logic             job_take,
  output logic                  job_valid,
  output job_t                  job
);

  localparam int PW = $clog2((MAX_ROW_WIDTH + 1) / 2 + 1);

  pair_t          pd0;
  pair_t          pd1;
  chroma_t        prev;
  logic [PW-1:0]  pos;

  pair_t              cur;
  logic [CALC_W-1:0]  rw;
  logic [CALC_W-1:0]  w;
  logic [CALC_W-1:0]  pairs;
  logic [CALC_W-1:0]  pos_ext;
  logic [CALC_W-1:0]  p_eff;
  logic               last;
  logic               has_out;
  logic               job_done;
  logic               in_accept;
  kind_t              start_kind;
  kind_t              kind_next;
  job_t               job_next;

  assign cur     = pair_t'(s_tdata);
  assign rw      = CALC_W'(row_width);
  assign pos_ext = CALC_W'(pos);

  always_comb begin
    if (rw == '0) begin
      w = CALC_W'(1);
    end else if (rw > CALC_W'(MAX_ROW_WIDTH)) begin
      w = CALC_W'(MAX_ROW_WIDTH);
    end else begin
      w = rw;
    end
  end

  assign pairs   = (w + CALC_W'(1)) >> 1;
  assign last    = pos_ext >= (pairs - CALC_W'(1));
  assign p_eff   = last ? (pairs - CALC_W'(1)) : pos_ext;
  assign has_out = last || (p_eff >= CALC_W'(2));

  assign job_done  = (job.kind == job.end_kind);
  assign s_tready  = !job_valid || (job_take && job_done);
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    if (p_eff >= CALC_W'(2)) begin
      start_kind = KIND_PREV2;
    end else if (p_eff == CALC_W'(1)) begin
      start_kind = KIND_PREV1;
    end else begin
      start_kind = KIND_CUR;
    end
  end

  always_comb begin
    case (job.kind)
      KIND_PREV2: kind_next = KIND_PREV1;
      KIND_PREV1: kind_next = KIND_CUR;
      default:    kind_next = KIND_CUR;
    endcase
  end

  always_comb begin
    job_next          = job;
    job_next.pd1      = pd1;
    job_next.pd0      = pd0;
    job_next.cur      = cur;
    job_next.prev     = prev;
    job_next.p_is0    = (p_eff == '0);
    job_next.p_is1    = (p_eff == CALC_W'(1));
    job_next.p_is2    = (p_eff == CALC_W'(2));
    job_next.odd_cur  = ((p_eff << 1) | CALC_W'(1)) < w;
    job_next.kind     = start_kind;
    job_next.end_kind = last ? KIND_CUR : KIND_PREV2;
  end

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      pd0  <= '0;
      pd1  <= '0;
      prev <= '0;
      pos  <= '0;
    end else if (in_accept) begin
      if (last) begin
        pd0  <= '0;
        pd1  <= '0;
        prev <= '0;
        pos  <= '0;
      end else begin
        prev <= chroma_t'({pd1.cr, pd1.cb});
        pd1  <= pd0;
        pd0  <= cur;
        pos  <= PW'(p_eff + CALC_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_accept) begin
      job_valid <= has_out;
    end else if (job_take && job_done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job <= job_next;
    end else if (job_take && !job_done) begin
      job.kind <= kind_next;
    end
  end

  // While a job is pending, a new pair only enters when that job hands over its final result.
  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    (in_accept && job_valid) |-> (job_take && job_done))
    else $error("pair accepted while job still had results pending");

  a_kind_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.kind <= job.end_kind))
    else $error("job stepped past its final result");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |=> (pos == '0))
    else $error("row position not cleared after last pair");

  a_last_job: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |=> (job_valid && job.end_kind == KIND_CUR))
    else $error("last pair did not start a flush job");

endmodule

`default_nettype wire

// ----- hdl/c422_emit.sv -----
// Operand selection, odd chroma interpolation and output register.
`default_nettype none

module c422_emit import c422_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  input  wire job_t        job,
  output logic             job_take,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,
  output logic [0:0]       m_tuser,
  output logic             m_tlast
);

  pair_t   pr;
  chroma_t b_op;
  chroma_t c_op;
  chroma_t d_op;
  logic    odd;
  logic    last;
  logic signed [15:0] cb_odd;
  logic signed [15:0] cr_odd;
  logic [95:0] data_next;

  always_comb begin
    case (job.kind)
      KIND_PREV1: begin
        pr   = job.pd0;
        b_op = chroma_t'({job.cur.cr, job.cur.cb});
        c_op = chroma_t'({job.cur.cr, job.cur.cb});
        d_op = job.p_is1 ? chroma_t'({job.pd0.cr, job.pd0.cb})
                         : chroma_t'({job.pd1.cr, job.pd1.cb});
        odd  = 1'b1;
        last = 1'b0;
      end
      KIND_CUR: begin
        pr   = job.cur;
        b_op = chroma_t'({job.cur.cr, job.cur.cb});
        c_op = chroma_t'({job.cur.cr, job.cur.cb});
        d_op = job.p_is0 ? chroma_t'({job.cur.cr, job.cur.cb})
                         : chroma_t'({job.pd0.cr, job.pd0.cb});
        odd  = job.odd_cur;
        last = 1'b1;
      end
      default: begin
        pr   = job.pd1;
        b_op = chroma_t'({job.pd0.cr, job.pd0.cb});
        c_op = chroma_t'({job.cur.cr, job.cur.cb});
        d_op = job.p_is2 ? chroma_t'({job.pd1.cr, job.pd1.cb}) : job.prev;
        odd  = 1'b1;
        last = 1'b0;
      end
    endcase
  end

  assign cb_odd = interp(pr.cb, b_op.cb, c_op.cb, d_op.cb);
  assign cr_odd = interp(pr.cr, b_op.cr, c_op.cr, d_op.cr);

  assign data_next = odd ? {cr_odd, cb_odd, pr.luma_odd, pr.cr, pr.cb, pr.luma_even}
                         : {48'd0, pr.cr, pr.cb, pr.luma_even};

  assign job_take = job_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (job_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      m_tdata <= data_next;
      m_tuser <= odd;
      m_tlast <= last;
    end
  end

  a_absent_odd_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[95:48] == '0))
    else $error("odd fields nonzero with odd pixel absent");

endmodule

`default_nettype wire
